[rtl/core/qdsf_pkg.sv]
// ----------------------------------------------------------------------------
// qdsf_pkg
// Shared constants for the quadrature decoder with speed filter: field widths,
// direction codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package qdsf_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int OUT_COUNT_W = 16;
    localparam int DIR_W       = 2;
    localparam int FILT_W      = 42;
    localparam int RAW_SAT_W   = 26;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ALPHA    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_PER_COUNT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET = 16'd655;
    localparam logic [CFG_DATA_W-1:0] SPC_RESET   = 16'd7500;

endpackage

`default_nettype wire

[rtl/core/qdsf_front.sv]
// ----------------------------------------------------------------------------
// qdsf_front
// Accepts pin samples, decodes the Gray phase step, keeps the saturating
// count and the direction, and pushes one work entry per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module qdsf_front #(
    parameter int COUNT_BITS = qdsf_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cmd,
    input  wire logic                               phase_a,
    input  wire logic                               phase_b,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output logic [COUNT_BITS+qdsf_pkg::DIR_W:0]     q_wdata
);
    import qdsf_pkg::*;

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = -CNT_MAX;

    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    logic signed [COUNT_BITS-1:0] count_reg;
    logic signed [COUNT_BITS-1:0] count_next;
    logic [DIR_W-1:0]             dir_reg;
    logic [DIR_W-1:0]             dir_next;
    logic [1:0]                   phase_now;
    logic [1:0]                   step;
    logic signed [COUNT_BITS-1:0] count_dec;
    logic [DIR_W-1:0]             dir_dec;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        if (!phase_b)
        begin
            phase_now = phase_a ? 2'd1 : 2'd0;
        end
        else
        begin
            phase_now = phase_a ? 2'd2 : 2'd3;
        end
        step      = phase_now - phase_reg;
        count_dec = count_reg;
        dir_dec   = dir_reg;
        case (step)
            2'd1:
            begin
                if (count_reg < CNT_MAX)
                begin
                    count_dec = count_reg + COUNT_BITS'(1);
                end
                dir_dec = DIR_FWD;
            end
            2'd3:
            begin
                if (count_reg > CNT_MIN)
                begin
                    count_dec = count_reg - COUNT_BITS'(1);
                end
                dir_dec = DIR_REV;
            end
            default:
            begin
                count_dec = count_reg;
                dir_dec   = dir_reg;
            end
        endcase

        phase_next = phase_reg;
        count_next = count_reg;
        dir_next   = dir_reg;
        if (q_push)
        begin
            phase_next = phase_now;
            dir_next   = dir_dec;
            count_next = cmd ? '0 : count_dec;
        end
        q_wdata = {cmd, dir_dec, count_dec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            dir_reg   <= DIR_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/qdsf_queue.sv]
// ----------------------------------------------------------------------------
// qdsf_queue
// Short register queue that decouples the decode front from the filter back.
// ----------------------------------------------------------------------------
`default_nettype none

module qdsf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qdsf_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      rdata
);
    import qdsf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rdata     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/qdsf_back.sv]
// ----------------------------------------------------------------------------
// qdsf_back
// Drains work entries, runs the speed update on a shared multiplier
// sequence, holds the filter value and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qdsf_back #(
    parameter int COUNT_BITS = qdsf_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    q_not_empty,
    input  wire logic [COUNT_BITS+qdsf_pkg::DIR_W:0]     q_rdata,
    output logic                                         q_pop,
    input  wire logic [qdsf_pkg::CFG_DATA_W-1:0]         filter_alpha,
    input  wire logic [qdsf_pkg::CFG_DATA_W-1:0]         speed_per_count,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [qdsf_pkg::OUT_COUNT_W-1:0]      period_count,
    output logic [qdsf_pkg::DIR_W-1:0]                   direction,
    output logic signed [qdsf_pkg::FILT_W-1:0]           smoothed_speed,
    output logic                                         speed_updated
);
    import qdsf_pkg::*;

    localparam int RAW_W  = COUNT_BITS + CFG_DATA_W + 1;
    localparam int DIFF_W = FILT_W + 1;
    localparam int LO_W   = 22;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int PP_W   = CFG_DATA_W + LO_W;
    localparam int PROD_W = CFG_DATA_W + 1 + DIFF_W;
    localparam int EXT_W  = 64;

    localparam logic signed [EXT_W-1:0] RAW_MAX = EXT_W'(33554431);
    localparam logic signed [EXT_W-1:0] RAW_MIN = -EXT_W'(33554432);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_PLO  = 3'd3;
    localparam logic [2:0] S_PHI  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic signed [FILT_W-1:0]     filt_reg;
    logic signed [FILT_W-1:0]     filt_next;
    logic signed [COUNT_BITS-1:0] cnt_reg;
    logic [DIR_W-1:0]             dir_reg;
    logic signed [RAW_W-1:0]      raw_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic [PP_W-1:0]              plo_reg;
    logic signed [PP_W-1:0]       phi_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic                         q_cmd;
    logic [DIR_W-1:0]             q_dir;
    logic signed [COUNT_BITS-1:0] q_cnt;
    logic                         out_free;
    logic                         out_load;
    logic signed [COUNT_BITS-1:0] load_cnt;
    logic [DIR_W-1:0]             load_dir;
    logic signed [FILT_W-1:0]     load_filt;
    logic                         load_upd;
    logic signed [EXT_W-1:0]      raw_ext;
    logic signed [RAW_SAT_W-1:0]  raw_sat;
    logic signed [FILT_W-1:0]     x_val;
    logic signed [HI_W-1:0]       diff_hi;
    logic signed [PROD_W-1:0]     prod;
    logic signed [PROD_W-1:0]     prod_shr;
    logic signed [FILT_W-1:0]     filt_upd;
    logic signed [31:0]           cnt_ext;

    assign q_cmd = q_rdata[COUNT_BITS+DIR_W];
    assign q_dir = q_rdata[COUNT_BITS+DIR_W-1:COUNT_BITS];
    assign q_cnt = $signed(q_rdata[COUNT_BITS-1:0]);

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        raw_ext = EXT_W'(raw_reg);
        if (raw_ext > RAW_MAX)
        begin
            raw_sat = RAW_MAX[RAW_SAT_W-1:0];
        end
        else if (raw_ext < RAW_MIN)
        begin
            raw_sat = RAW_MIN[RAW_SAT_W-1:0];
        end
        else
        begin
            raw_sat = raw_ext[RAW_SAT_W-1:0];
        end
        x_val    = {raw_sat, 16'b0};
        diff_hi  = diff_reg[DIFF_W-1:LO_W];
        prod     = (PROD_W'(phi_reg) <<< LO_W) + $signed(PROD_W'(plo_reg));
        prod_shr = prod >>> 16;
        filt_upd = filt_reg + prod_shr[FILT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        filt_next  = filt_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        load_cnt   = q_cnt;
        load_dir   = q_dir;
        load_filt  = filt_reg;
        load_upd   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    if (q_cmd)
                    begin
                        q_pop      = 1'b1;
                        state_next = S_MUL;
                    end
                    else if (out_free)
                    begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_PLO;
            end
            S_PLO:
            begin
                state_next = S_PHI;
            end
            S_PHI:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                load_cnt  = cnt_reg;
                load_dir  = dir_reg;
                load_filt = filt_upd;
                load_upd  = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    filt_next  = filt_upd;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
        cnt_ext = 32'(load_cnt);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cnt_reg <= q_cnt;
            dir_reg <= q_dir;
        end
        if (state_reg == S_MUL)
        begin
            raw_reg <= cnt_reg * $signed({1'b0, speed_per_count});
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= DIFF_W'(x_val) - DIFF_W'(filt_reg);
        end
        if (state_reg == S_PLO)
        begin
            plo_reg <= PP_W'(filter_alpha) * PP_W'(diff_reg[LO_W-1:0]);
        end
        if (state_reg == S_PHI)
        begin
            phi_reg <= PP_W'($signed({1'b0, filter_alpha})) * PP_W'(diff_hi);
        end
        if (out_load)
        begin
            period_count   <= cnt_ext[OUT_COUNT_W-1:0];
            direction      <= load_dir;
            smoothed_speed <= load_filt;
            speed_updated  <= load_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filt_reg      <= filt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/quadrature_decoder_speed_filter.sv]
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_filter
// A decode-only sample passes through the queue and the result register,
// and one such sample per cycle is sustained while out_stall is low and no
// speed update is in progress. A speed update sample steps through S_MUL,
// S_DIFF, S_PLO, S_PHI and S_FIN of the shared filter multiplier sequence.
// Reset clears count, phase, direction and filter value and restores the
// default filter_alpha and speed_per_count.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_decoder_speed_filter #(
    parameter int COUNT_BITS = qdsf_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic                                phase_a,
    input  wire logic                                phase_b,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [qdsf_pkg::OUT_COUNT_W-1:0]  period_count,
    output logic [qdsf_pkg::DIR_W-1:0]               direction,
    output logic signed [qdsf_pkg::FILT_W-1:0]       smoothed_speed,
    output logic                                     speed_updated,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [qdsf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [qdsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qdsf_pkg::*;

    localparam int ENTRY_W = COUNT_BITS + DIR_W + 1;

    logic [CFG_DATA_W-1:0] alpha_reg;
    logic [CFG_DATA_W-1:0] alpha_next;
    logic [CFG_DATA_W-1:0] spc_reg;
    logic [CFG_DATA_W-1:0] spc_next;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;
    logic [ENTRY_W-1:0]    q_wdata;
    logic [ENTRY_W-1:0]    q_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_next = alpha_reg;
        spc_next   = spc_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FILTER_ALPHA:    alpha_next = cfg_data;
                CFG_SPEED_PER_COUNT: spc_next   = cfg_data;
                default:             alpha_next = alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            spc_reg   <= SPC_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
            spc_reg   <= spc_next;
        end
    end

    qdsf_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .phase_a  (phase_a),
        .phase_b  (phase_b),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    qdsf_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    qdsf_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .filter_alpha    (alpha_reg),
        .speed_per_count (spc_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .period_count    (period_count),
        .direction       (direction),
        .smoothed_speed  (smoothed_speed),
        .speed_updated   (speed_updated)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Quadrature decoder speed filter testbench
// Drives pin samples through the decoder with random idle bursts on both
// channels, tracks the phase, count, direction and filter value in a
// scoreboard, and checks every result transfer in order. Configuration is
// changed only while the block is idle. A long run of steps in each direction
// drives the raw speed into saturation.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qdsf_pkg::*;

    localparam int COUNT_LIMIT = (1 << (COUNT_BITS_DEFAULT - 1)) - 1;
    localparam int SAT_STEPS = 520;
    localparam longint RAW_HIGH = 64'sd33554431;
    localparam longint RAW_LOW = -64'sd33554432;

    typedef struct {
        logic [OUT_COUNT_W-1:0] count;
        logic [DIR_W-1:0]       dir;
        logic [FILT_W-1:0]      speed;
        logic                   updated;
    } sample_result_t;

    class speed_scoreboard;
        int alpha;
        int spc;
        logic [1:0] last_phase;
        int count;
        logic [DIR_W-1:0] dir;
        longint speed_q16;
        sample_result_t pending_results[$];
        int errors;

        function new();
            alpha = ALPHA_RESET;
            spc = SPC_RESET;
            last_phase = 2'd0;
            count = 0;
            dir = DIR_NONE;
            speed_q16 = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FILTER_ALPHA)
                alpha = data;
            else if (idx == CFG_SPEED_PER_COUNT)
                spc = data;
        endfunction

        function void note_sample(bit c, bit a, bit b);
            logic [1:0] ph;
            logic [1:0] step;
            longint raw;
            longint gap_q16;
            sample_result_t r;
            ph = b ? (a ? 2'd2 : 2'd3) : (a ? 2'd1 : 2'd0);
            step = ph - last_phase;
            if (step == 2'd1)
            begin
                if (count < COUNT_LIMIT)
                    count++;
                dir = DIR_FWD;
            end
            else if (step == 2'd3)
            begin
                if (count > -COUNT_LIMIT)
                    count--;
                dir = DIR_REV;
            end
            last_phase = ph;
            r.count = count[OUT_COUNT_W-1:0];
            if (c)
            begin
                raw = longint'(count) * longint'(spc);
                if (raw > RAW_HIGH)
                    raw = RAW_HIGH;
                if (raw < RAW_LOW)
                    raw = RAW_LOW;
                gap_q16 = raw * 65536 - speed_q16;
                speed_q16 = speed_q16 + ((longint'(alpha) * gap_q16) >>> 16);
                count = 0;
            end
            r.dir = dir;
            r.speed = speed_q16[FILT_W-1:0];
            r.updated = c;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_COUNT_W-1:0] cnt, logic [DIR_W-1:0] d,
                                   logic [FILT_W-1:0] spd, logic upd);
            sample_result_t r;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no sample pending");
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (cnt !== r.count)
            begin
                $error("period_count: expected %0d, actual %0d",
                       $signed(r.count), $signed(cnt));
                errors++;
            end
            if (d !== r.dir)
            begin
                $error("direction: expected %0d, actual %0d", r.dir, d);
                errors++;
            end
            if (spd !== r.speed)
            begin
                $error("smoothed_speed: expected %0d, actual %0d",
                       $signed(r.speed), $signed(spd));
                errors++;
            end
            if (upd !== r.updated)
            begin
                $error("speed_updated: expected %0d, actual %0d", r.updated, upd);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic phase_a = 1'b0;
    logic phase_b = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_COUNT_W-1:0] period_count;
    logic [DIR_W-1:0] direction;
    logic signed [FILT_W-1:0] smoothed_speed;
    logic speed_updated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FILTER_ALPHA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    speed_scoreboard board = new();
    bit calm = 1'b0;
    logic [1:0] cur_phase = 2'd0;

    quadrature_decoder_speed_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .phase_a       (phase_a),
        .phase_b       (phase_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .period_count  (period_count),
        .direction     (direction),
        .smoothed_speed(smoothed_speed),
        .speed_updated (speed_updated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            board.check_result(period_count, direction, smoothed_speed, speed_updated);
    end

    initial
    begin
        int burst_left;
        int quiet_left;
        burst_left = 0;
        quiet_left = 0;
        forever
        begin
            @(negedge clk);
            if (calm || quiet_left > 0)
            begin
                out_stall = 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall = 1'b1;
                burst_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if ($urandom_range(0, 40) == 0)
                    quiet_left = $urandom_range(20, 80);
                else if ($urandom_range(0, 5) == 0)
                    burst_left = $urandom_range(1, 9);
            end
        end
    end

    task automatic send_sample(bit c, bit a, bit b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 6) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        phase_a = a;
        phase_b = b;
        do @(posedge clk); while (in_stall !== 1'b0);
        board.note_sample(c, a, b);
    endtask

    task automatic send_phase(bit c, logic [1:0] ph);
        cur_phase = ph;
        send_sample(c, ph == 2'd1 || ph == 2'd2, ph[1]);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_filter(logic [CFG_DATA_W-1:0] alpha, logic [CFG_DATA_W-1:0] spc);
        wait_idle();
        write_reg(CFG_FILTER_ALPHA, alpha);
        write_reg(CFG_SPEED_PER_COUNT, spc);
    endtask

    task automatic random_phase(int target);
        int sent;
        int len;
        int r;
        bit fwd;
        logic [1:0] ph;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    send_sample($urandom_range(0, 3) == 0, $urandom_range(0, 1),
                                $urandom_range(0, 1));
                    cur_phase = board.last_phase;
                end
            end
            else
            begin
                fwd = $urandom_range(0, 1);
                len = $urandom_range(1, 60);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        ph = fwd ? cur_phase + 2'd1 : cur_phase - 2'd1;
                    else if (r < 90)
                        ph = fwd ? cur_phase - 2'd1 : cur_phase + 2'd1;
                    else if (r < 95)
                        ph = cur_phase;
                    else
                        ph = cur_phase + 2'd2;
                    send_phase($urandom_range(0, 9) == 0 || (i == len - 1 &&
                               $urandom_range(0, 1) == 1), ph);
                end
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send_phase(1'b0, 2'd0);
        send_phase(1'b1, 2'd0);
        send_phase(1'b0, 2'd1);
        send_phase(1'b0, 2'd2);
        send_phase(1'b0, 2'd3);
        send_phase(1'b0, 2'd0);
        send_phase(1'b1, 2'd1);
        send_phase(1'b0, 2'd0);
        send_phase(1'b0, 2'd3);
        send_phase(1'b0, 2'd2);
        send_phase(1'b0, 2'd0);
        send_phase(1'b1, 2'd2);
        send_phase(1'b1, 2'd3);
        send_phase(1'b0, 2'd1);
        send_phase(1'b1, 2'd1);
        send_phase(1'b1, 2'd2);

        set_filter(16'hFFFF, 16'hFFFF);
        send_phase(1'b0, 2'd3);
        send_phase(1'b1, 2'd0);
        send_phase(1'b0, 2'd3);
        send_phase(1'b1, 2'd2);
        set_filter(16'h0000, 16'h0000);
        send_phase(1'b0, 2'd3);
        send_phase(1'b1, 2'd0);

        set_filter(16'hFFFF, 16'hFFFF);
        calm = 1'b1;
        repeat (SAT_STEPS) send_phase(1'b0, cur_phase + 2'd1);
        send_phase(1'b1, cur_phase + 2'd1);
        send_phase(1'b1, cur_phase + 2'd1);
        set_filter(16'd40000, 16'hFFFF);
        repeat (SAT_STEPS) send_phase(1'b0, cur_phase - 2'd1);
        send_phase(1'b1, cur_phase - 2'd1);
        calm = 1'b0;

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_filter(ALPHA_RESET, SPC_RESET);
                1: set_filter(16'h0000, 16'hFFFF);
                2: set_filter(16'hFFFF, 16'h0001);
                3: set_filter(16'h0001, 16'h0000);
                4: set_filter(16'hFFFF, 16'hFFFF);
                default: set_filter($urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            if (p == 7)
                calm = 1'b1;
            random_phase(20);
        end

        wait_idle();
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
